// ===== rtl/core/efs_pkg.sv =====
// Shared types and constants for the e-paper frame store and line formatter.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package efs_pkg;

  localparam int WIDTH_DEF  = 264;
  localparam int HEIGHT_DEF = 176;

  localparam int CMD_W  = 3;
  localparam int X_W    = 9;
  localparam int Y_W    = 8;
  localparam int CODE_W = 2;
  localparam int DATA_W = 16;
  localparam int CFG_W  = 2;

  localparam int HALF_BYTES = 33;
  localparam int SCAN_BYTES = 44;
  localparam int LINE_BYTES = HALF_BYTES + SCAN_BYTES + HALF_BYTES;
  localparam int ASC_START  = HALF_BYTES + SCAN_BYTES;

  localparam logic [7:0] SCAN_MARK = 8'd192;
  localparam logic [CODE_W-1:0] SCAN_CODE = SCAN_MARK[7:6];

  localparam logic [CODE_W-1:0] BLACK_RST    = 2'd3;
  localparam logic [CODE_W-1:0] WHITE_RST    = 2'd2;
  localparam logic [CODE_W-1:0] NOCHANGE_RST = 2'd0;

  typedef enum logic [CFG_W-1:0] {
    CFG_BLACK    = 2'd0,
    CFG_WHITE    = 2'd1,
    CFG_NOCHANGE = 2'd2
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET      = 3'd0,
    CMD_GET      = 3'd1,
    CMD_FILL     = 3'd2,
    CMD_FILL_ALL = 3'd3,
    CMD_EMIT     = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SET,
    S_GET,
    S_GET_WAIT,
    S_FILL,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/core/efs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module efs_ram #(
  parameter int DATA_W = 2,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/epaper_frame_store_line_formatter.sv =====
// Top level of the e-paper frame store and line formatter.
// Depends on efs_pkg and efs_ram (pixel store, one pixel per entry).
// Emit walks four 2-bit slots per byte, one slot a cycle through the single read port,
// except that the last slot of each word waits until the output register is free.
// Throughput: one command at a time; an idle block takes a command while a result waits.
// Reset: the control state clears at once, then a clearing pass writes the white code to
// every pixel, with no command accepted.
`timescale 1ns / 1ps

module epaper_frame_store_line_formatter #(
  parameter int WIDTH  = efs_pkg::WIDTH_DEF,
  parameter int HEIGHT = efs_pkg::HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [efs_pkg::CMD_W-1:0]   command,
  input  logic [efs_pkg::X_W-1:0]     x,
  input  logic [efs_pkg::Y_W-1:0]     y,
  input  logic [efs_pkg::X_W-1:0]     end_x,
  input  logic [efs_pkg::Y_W-1:0]     end_y,
  input  logic [efs_pkg::CODE_W-1:0]  color,
  input  logic                        inverted,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [efs_pkg::DATA_W-1:0]  data,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [efs_pkg::CFG_W-1:0]   cfg_index,
  input  logic [efs_pkg::CODE_W-1:0]  cfg_data
);

  import efs_pkg::*;

  localparam int DEPTH = WIDTH * HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(WIDTH);
  localparam int YW    = $clog2(HEIGHT);
  localparam int OFFW  = 10;

  localparam logic [OFFW-1:0] W_LAST     = OFFW'(WIDTH - 1);
  localparam logic [X_W:0]    X_MAX      = (X_W + 1)'(WIDTH - 1);
  localparam logic [Y_W:0]    Y_MAX      = (Y_W + 1)'(HEIGHT - 1);
  localparam logic [6:0]      HALF_B     = 7'(HALF_BYTES);
  localparam logic [6:0]      ASC_B      = 7'(ASC_START);
  localparam logic [6:0]      LAST_B     = 7'(LINE_BYTES - 1);

  state_t state, state_next;

  logic [CODE_W-1:0] black_code, white_code, nochange_code;

  cmd_t              cmd_q;
  logic [XW-1:0]     x0;
  logic [YW-1:0]     y0;
  logic [XW:0]       ex_q;
  logic [YW:0]       ey_q;
  logic [CODE_W-1:0] color_q;
  logic              inv_q;

  logic [XW-1:0]     col;
  logic [YW-1:0]     row;
  logic [AW-1:0]     row_base;
  logic [6:0]        byte_idx;
  logic [1:0]        slot;

  logic              a_valid, a_mem, a_word_done, a_last;
  logic [CODE_W-1:0] a_const;
  logic [13:0]       acc;

  logic [XW-1:0]     xc, exc;
  logic [YW-1:0]     yc, eyc;
  logic              accept, out_free, fill_empty;
  logic              col_wrap, row_done;

  logic              is_desc, is_scan, slot_pad, scan_hit, word_final, line_done;
  logic [6:0]        b_rel, scan_j;
  logic [OFFW-1:0]   off;
  logic [XW-1:0]     emit_col;
  logic [CODE_W-1:0] slot_const;

  logic              wr_en, rd_en, issue, get_load;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CODE_W-1:0] rd_data, mapped, b_code;
  logic              b_load;

  efs_ram #(
    .DATA_W (CODE_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (color_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // clamp coordinates to the panel edge
  always_comb begin
    xc  = ({1'b0, x} > X_MAX) ? XW'(X_MAX) : XW'(x);
    exc = ({1'b0, end_x} > X_MAX) ? XW'(X_MAX) : XW'(end_x);
    yc  = ({1'b0, y} > Y_MAX) ? YW'(Y_MAX) : YW'(y);
    eyc = ({1'b0, end_y} > Y_MAX) ? YW'(Y_MAX) : YW'(end_y);
  end

  assign fill_empty = ({1'b0, x0} >= ex_q) || ({1'b0, y0} >= ey_q);
  assign col_wrap   = ({1'b0, col} + (XW + 1)'(1)) == ex_q;
  assign row_done   = ({1'b0, row} + (YW + 1)'(1)) == ey_q;

  // line slot decode
  always_comb begin
    is_desc  = byte_idx < HALF_B;
    is_scan  = !is_desc && (byte_idx < ASC_B);
    b_rel    = is_desc ? byte_idx : byte_idx - ASC_B;
    off      = OFFW'({b_rel, 3'b000}) + OFFW'({slot, 1'b0});
    slot_pad = off > W_LAST;
    emit_col = is_desc ? XW'(W_LAST - off) : XW'(off);
    scan_j   = byte_idx - HALF_B;
    scan_hit = (scan_j == 7'(y0 >> 2)) && (slot == 2'(y0));
    slot_const = (is_scan && scan_hit) ? SCAN_CODE : '0;
    word_final = (slot == 2'd3) && byte_idx[0];
    line_done  = (slot == 2'd3) && (byte_idx == LAST_B);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        case (cmd_q)
          CMD_SET:      state_next = S_SET;
          CMD_GET:      state_next = S_GET;
          CMD_FILL:     state_next = fill_empty ? S_IDLE : S_FILL;
          CMD_FILL_ALL: state_next = S_FILL;
          CMD_EMIT:     state_next = S_EMIT;
          default:      state_next = S_IDLE;
        endcase
      end
      S_SET:      state_next = S_IDLE;
      S_GET: begin
        if (out_free) begin
          state_next = S_GET_WAIT;
        end
      end
      S_GET_WAIT: state_next = S_IDLE;
      S_FILL: begin
        if (col_wrap && row_done) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (issue && line_done) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    issue    = 1'b0;
    get_load = 1'b0;
    wr_addr  = row_base + AW'(col);
    rd_addr  = row_base + AW'(col);
    case (state)
      S_IDLE:     in_ready = 1'b1;
      S_SET:      wr_en = 1'b1;
      S_FILL:     wr_en = 1'b1;
      S_GET:      rd_en = out_free;
      S_GET_WAIT: get_load = 1'b1;
      S_EMIT: begin
        issue   = !word_final || out_free;
        rd_en   = issue && !is_scan && !slot_pad;
        rd_addr = row_base + AW'(emit_col);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (rd_data == black_code) begin
      mapped = white_code;
    end else if (rd_data == white_code) begin
      mapped = black_code;
    end else begin
      mapped = nochange_code;
    end
    b_code = a_mem ? (inv_q ? mapped : rd_data) : a_const;
    b_load = a_valid && a_word_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL;
      black_code    <= BLACK_RST;
      white_code    <= WHITE_RST;
      nochange_code <= NOCHANGE_RST;
      cmd_q         <= CMD_FILL_ALL;
      x0            <= '0;
      y0            <= '0;
      ex_q          <= (XW + 1)'(WIDTH);
      ey_q          <= (YW + 1)'(HEIGHT);
      color_q       <= WHITE_RST;
      col           <= '0;
      row           <= '0;
      row_base      <= '0;
      a_valid       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BLACK:    black_code    <= cfg_data;
          CFG_WHITE:    white_code    <= cfg_data;
          CFG_NOCHANGE: nochange_code <= cfg_data;
          default:      black_code    <= black_code;
        endcase
      end

      if (accept) begin
        cmd_q   <= cmd_t'(command);
        color_q <= color;
        inv_q   <= inverted;
        if (cmd_t'(command) == CMD_FILL) begin
          x0   <= (xc > exc) ? exc : xc;
          y0   <= (yc > eyc) ? eyc : yc;
          ex_q <= {1'b0, exc};
          ey_q <= {1'b0, eyc};
        end else if (cmd_t'(command) == CMD_FILL_ALL) begin
          x0   <= '0;
          y0   <= '0;
          ex_q <= (XW + 1)'(WIDTH);
          ey_q <= (YW + 1)'(HEIGHT);
        end else begin
          x0   <= xc;
          y0   <= yc;
          ex_q <= {1'b0, exc};
          ey_q <= {1'b0, eyc};
        end
      end

      if (state == S_PREP) begin
        row_base <= AW'(y0 * WIDTH);
        col      <= x0;
        row      <= y0;
        byte_idx <= '0;
        slot     <= '0;
      end

      // advance the fill walk
      if (state == S_FILL) begin
        if (col_wrap) begin
          col      <= x0;
          row      <= row + YW'(1);
          row_base <= row_base + AW'(WIDTH);
        end else begin
          col <= col + XW'(1);
        end
      end

      // issue one line slot
      a_valid <= issue;
      if (issue) begin
        a_mem       <= !is_scan && !slot_pad;
        a_const     <= slot_const;
        a_word_done <= word_final;
        a_last      <= line_done;
        slot        <= slot + 2'd1;
        if (slot == 2'd3) begin
          byte_idx <= byte_idx + 7'd1;
        end
      end

      if (a_valid) begin
        acc <= {acc[11:0], b_code};
      end

      // output register
      if (get_load) begin
        out_valid <= 1'b1;
        data      <= DATA_W'(rd_data);
        last      <= 1'b1;
      end else if (b_load) begin
        out_valid <= 1'b1;
        data      <= {acc, b_code};
        last      <= a_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_PREP)
    else $error("accepted command did not enter setup");

  a_slot_source: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> $past(state == S_EMIT))
    else $error("line slot outside of emit");

  a_get_free: assert property (@(posedge clk) disable iff (rst)
    state == S_GET_WAIT |-> !out_valid)
    else $error("pixel read result would overwrite a pending transfer");

  a_word_free: assert property (@(posedge clk) disable iff (rst)
    b_load |-> !out_valid && !get_load)
    else $error("line word would overwrite a pending transfer");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (int'(wr_addr) < DEPTH) && !rd_en)
    else $error("store write out of range or overlapping a read");

endmodule
